### rtl/vda_pkg.sv
// Package for the vector distance accumulator: shared constants, types and codes.
// Depends on nothing.
package vda_pkg;
  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned ElemWidth = 16;
  localparam int unsigned AccWidth  = 48;
  localparam int unsigned CntWidth  = $clog2(MaxDim + 1);
  localparam int unsigned FracBits  = 24;

  localparam logic [1:0] MetricL2  = 2'd0;
  localparam logic [1:0] MetricDot = 2'd1;
  localparam logic [1:0] MetricCos = 2'd2;

  localparam logic [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  typedef struct packed {
    logic acc_en;      // accumulate the staged products
    logic clear;       // clear the accumulators
    logic mul_start;   // start norm product
    logic sqrt_start;  // start square root
    logic div_start;   // start quotient
    logic out_load;    // load output register
  } vda_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic zero;
  } vda_sts_t;
endpackage

### rtl/vda_datapath.sv
// Datapath: element MACs with saturating sums, serial norm multiply, serial isqrt and divide.
// Depends on vda_pkg.
module vda_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [vda_pkg::ElemWidth-1:0] elem_a_i,
  input  logic signed [vda_pkg::ElemWidth-1:0] elem_b_i,
  input  logic                                 take_i,
  input  logic [1:0]                           metric_i,
  input  vda_pkg::vda_cmd_t                    cmd_i,
  output vda_pkg::vda_sts_t                    sts_o,
  output logic signed [vda_pkg::AccWidth-1:0]  distance_o,
  output logic                                 zero_norm_o
);
  import vda_pkg::*;

  localparam int unsigned PW = 2 * ElemWidth + 2;

  logic signed [PW-1:0] p_sq_q, p_pr_q, p_a_q, p_b_q;
  logic signed [ElemWidth:0] diff;
  logic signed [AccWidth-1:0] s_sq_q, s_pr_q, n_a_q, n_b_q;
  logic signed [AccWidth-1:0] s_sq_d, s_pr_d, n_a_d, n_b_d;

  function automatic logic [AccWidth-1:0] sat_add(logic [AccWidth-1:0] acc,
                                                  logic signed [PW-1:0] t);
    logic signed [AccWidth:0] s;
    s = $signed({acc[AccWidth-1], acc}) + (AccWidth+1)'(t);
    if (s[AccWidth] != s[AccWidth-1]) return s[AccWidth] ? AccMin : AccMax;
    return s[AccWidth-1:0];
  endfunction

  assign diff = {elem_a_i[ElemWidth-1], elem_a_i} - {elem_b_i[ElemWidth-1], elem_b_i};

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      p_sq_q <= PW'(diff * diff);
      p_pr_q <= PW'(elem_a_i * elem_b_i);
      p_a_q  <= PW'(elem_a_i * elem_a_i);
      p_b_q  <= PW'(elem_b_i * elem_b_i);
    end
  end

  always_comb begin
    s_sq_d = sat_add(s_sq_q, p_sq_q);
    s_pr_d = sat_add(s_pr_q, p_pr_q);
    n_a_d  = sat_add(n_a_q, p_a_q);
    n_b_d  = sat_add(n_b_q, p_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_sq_q <= '0; s_pr_q <= '0; n_a_q <= '0; n_b_q <= '0;
    end else if (cmd_i.clear) begin
      s_sq_q <= '0; s_pr_q <= '0; n_a_q <= '0; n_b_q <= '0;
    end else if (cmd_i.acc_en) begin
      s_sq_q <= s_sq_d; s_pr_q <= s_pr_d; n_a_q <= n_a_d; n_b_q <= n_b_d;
    end
  end

  // norm product: shift-add, 2 bits per cycle over 48-bit multiplier
  logic [2*AccWidth-1:0] prod_q;
  logic [2*AccWidth-1:0] mcand_q;
  logic [AccWidth-1:0]   mplier_q;
  logic [5:0]            mcnt_q;
  logic                  mbusy_q, mdone_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0; mdone_q <= 1'b0; mcnt_q <= '0;
    end else begin
      mdone_q <= 1'b0;
      if (cmd_i.mul_start) begin
        mbusy_q <= 1'b1; mcnt_q <= 6'd24;
        prod_q <= '0; mcand_q <= {{AccWidth{1'b0}}, n_a_q}; mplier_q <= n_b_q;
      end else if (mbusy_q) begin
        prod_q <= prod_q + (mplier_q[0] ? mcand_q : '0)
                         + (mplier_q[1] ? {mcand_q[2*AccWidth-2:0], 1'b0} : '0);
        mcand_q  <= {mcand_q[2*AccWidth-3:0], 2'b00};
        mplier_q <= {2'b00, mplier_q[AccWidth-1:2]};
        mcnt_q   <= mcnt_q - 6'd1;
        if (mcnt_q == 6'd1) begin
          mbusy_q <= 1'b0; mdone_q <= 1'b1;
        end
      end
    end
  end

  // floor square root, one result bit per cycle (restoring)
  logic [2*AccWidth-1:0] rad_q;
  logic [AccWidth+1:0]   rem_q;
  logic [AccWidth-1:0]   root_q;
  logic [5:0]            scnt_q;
  logic                  sbusy_q, sdone_q;
  logic [AccWidth+1:0]   s_trial, s_rem;
  always_comb begin
    s_rem   = {rem_q[AccWidth-1:0], rad_q[2*AccWidth-1 -: 2]};
    s_trial = s_rem - {root_q, 2'b01};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0; sdone_q <= 1'b0; scnt_q <= '0;
    end else begin
      sdone_q <= 1'b0;
      if (cmd_i.sqrt_start) begin
        sbusy_q <= 1'b1; scnt_q <= 6'(AccWidth);
        rad_q <= prod_q; rem_q <= '0; root_q <= '0;
      end else if (sbusy_q) begin
        rad_q <= {rad_q[2*AccWidth-3:0], 2'b00};
        if (!s_trial[AccWidth+1]) begin
          rem_q <= s_trial; root_q <= {root_q[AccWidth-2:0], 1'b1};
        end else begin
          rem_q <= s_rem;   root_q <= {root_q[AccWidth-2:0], 1'b0};
        end
        scnt_q <= scnt_q - 6'd1;
        if (scnt_q == 6'd1) begin
          sbusy_q <= 1'b0; sdone_q <= 1'b1;
        end
      end
    end
  end

  // quotient |dot| / root, 24 fraction bits, one per cycle
  logic [AccWidth:0]   mag;
  logic [AccWidth:0]   drem_q;
  logic [FracBits-1:0] q_q;
  logic [4:0]          dcnt_q;
  logic                dbusy_q, ddone_q, dsat_q;
  logic [AccWidth+1:0] d_sh, d_sub;
  assign mag   = s_pr_q[AccWidth-1] ? -{s_pr_q[AccWidth-1], s_pr_q}
                                    : {1'b0, s_pr_q};
  assign d_sh  = {drem_q, 1'b0};
  assign d_sub = d_sh - {2'b00, root_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0; ddone_q <= 1'b0; dcnt_q <= '0; dsat_q <= 1'b0;
    end else begin
      ddone_q <= 1'b0;
      if (cmd_i.div_start) begin
        dsat_q <= (mag >= {1'b0, root_q});
        drem_q <= mag; q_q <= '0;
        dbusy_q <= 1'b1; dcnt_q <= 5'(FracBits);
      end else if (dbusy_q) begin
        if (!d_sub[AccWidth+1]) begin
          drem_q <= d_sub[AccWidth:0]; q_q <= {q_q[FracBits-2:0], 1'b1};
        end else begin
          drem_q <= d_sh[AccWidth:0];  q_q <= {q_q[FracBits-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 5'd1;
        if (dcnt_q == 5'd1) begin
          dbusy_q <= 1'b0; ddone_q <= 1'b1;
        end
      end
    end
  end

  logic zero;
  assign zero = (n_a_q == '0) || (n_b_q == '0);

  logic [FracBits:0]           qv;
  logic signed [AccWidth-1:0]  dist_val;
  assign qv = dsat_q ? {1'b1, {FracBits{1'b0}}} : {1'b0, q_q};
  always_comb begin
    case (metric_i)
      MetricDot: dist_val = (s_pr_q == AccMin) ? AccMax : -s_pr_q;
      MetricCos: begin
        if (zero) dist_val = AccWidth'(1) << FracBits;
        else if (s_pr_q[AccWidth-1])
          dist_val = (AccWidth'(1) << FracBits) + AccWidth'(qv);
        else
          dist_val = (AccWidth'(1) << FracBits) - AccWidth'(qv);
      end
      default: dist_val = s_sq_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      distance_o  <= dist_val;
      zero_norm_o <= (metric_i == MetricCos) && zero;
    end
  end

  assign sts_o = '{mul_done: mdone_q, sqrt_done: sdone_q, div_done: ddone_q, zero: zero};
endmodule

### rtl/vda_ctrl.sv
// Controller: sequences accumulation, closes vectors, runs the cosine back end.
// Depends on vda_pkg.
module vda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [1:0]        metric_i,
  output logic              take_o,
  output vda_pkg::vda_cmd_t cmd_o,
  input  vda_pkg::vda_sts_t sts_i
);
  import vda_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAcc  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StSqrt = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StChk  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic close_q, close_d, ovld_q, ovld_d;
  logic ready;

  assign ready = (state_q == StIdle);
  assign in_ready_o = ready;
  assign take_o = in_valid_i && ready;
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; close_d = close_q;
    ovld_d = ovld_q && !out_ready_i;
    cmd_o = '0;
    case (state_q)
      StIdle: if (take_o) begin
        state_d = StAcc;
        close_d = last_i || (cnt_q == CntWidth'(MaxDim - 1));
        cnt_d   = close_d ? '0 : cnt_q + 1'b1;
      end
      StAcc: begin
        cmd_o.acc_en = 1'b1;
        if (!close_q) state_d = StIdle;
        else if (metric_i == MetricCos) state_d = StChk;
        else state_d = StOut;
      end
      // norms are settled here
      StChk: begin
        if (sts_i.zero) state_d = StOut;
        else begin
          cmd_o.mul_start = 1'b1; state_d = StMul;
        end
      end
      StMul: if (sts_i.mul_done) begin
        cmd_o.sqrt_start = 1'b1; state_d = StSqrt;
      end
      StSqrt: if (sts_i.sqrt_done) begin
        cmd_o.div_start = 1'b1; state_d = StDiv;
      end
      StDiv: if (sts_i.div_done) state_d = StOut;
      StOut: if (!ovld_q || out_ready_i) begin
        cmd_o.out_load = 1'b1; cmd_o.clear = 1'b1;
        ovld_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; close_q <= 1'b0; ovld_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; close_q <= close_d; ovld_q <= ovld_d;
    end
  end
endmodule

### rtl/vector_distance_accumulator.sv
// Top level of the vector distance accumulator: controller, datapath, APB register.
// Depends on vda_pkg, vda_ctrl, vda_datapath.
//
// Usage: element pairs (elem_a_i, elem_b_i, last_i) arrive on a valid/ready
// channel; one word per vector leaves on the output channel (distance_o,
// zero_norm_o) once the closing element has been taken. A vector also closes
// after 4096 elements. metric is written over the APB port at address 0.
// Each element is taken, then accumulated with saturation, before the next
// one is taken; a closing element holds the input until its word has been
// loaded into the output register.
// From the closing element to out_valid_o the controller runs the accumulate
// and output-load states for L2 or dot, adds the norm check for a zero norm,
// and for cosine also the norm multiply, the square root and the divide.
// Reset clears the accumulators, the element count and sets metric to L2.
// When the receiver stalls the output word holds; elements of the next
// vector are still taken, and its result is loaded only once the old word has left.
module vector_distance_accumulator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [vda_pkg::ElemWidth-1:0] elem_a_i,
  input  logic signed [vda_pkg::ElemWidth-1:0] elem_b_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [vda_pkg::AccWidth-1:0]  distance_o,
  output logic                                 zero_norm_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [1:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import vda_pkg::*;

  logic [1:0] metric_q;
  vda_cmd_t cmd;
  vda_sts_t sts;
  logic take;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) metric_q <= MetricL2;
    else if (psel && penable && pwrite && paddr == 2'd0) metric_q <= pwdata[1:0];
  end
  assign prdata = (paddr == 2'd0) ? {30'd0, metric_q} : '0;

  vda_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .last_i,
    .out_valid_o, .out_ready_i, .metric_i(metric_q),
    .take_o(take), .cmd_o(cmd), .sts_i(sts)
  );

  vda_datapath u_dp (
    .clk_i, .rst_ni, .elem_a_i, .elem_b_i, .take_i(take),
    .metric_i(metric_q), .cmd_i(cmd), .sts_o(sts),
    .distance_o, .zero_norm_o
  );
endmodule
